[src/assert_macros.svh]
// concurrent assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// checked only while out of reset
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// checked at every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

[src/aass_pkg.sv]
package aass_pkg;

    localparam int unsigned ANGLE_W = 17;
    localparam int unsigned MAGIC_W = 18;
    localparam int unsigned PROD_W  = ANGLE_W + MAGIC_W;
    localparam int unsigned VAL_W   = 10;
    localparam int unsigned DIGIT_W = 4;
    localparam int unsigned SEG_W   = 7;

    localparam logic [ANGLE_W-1:0] ANGLE_MAX = 17'd99999;
    localparam logic [ANGLE_W-1:0] HUNDS_MIN = 17'd10000;
    localparam logic [ANGLE_W-1:0] TENS_MIN  = 17'd1000;

    // reciprocal multipliers: floor(h / 100) = (h * 167773) >> 24 and
    // floor(h / 10) = (h * 52429) >> 19 over the saturated input range
    localparam logic [MAGIC_W-1:0] MAGIC_DIV100 = 18'd167773;
    localparam logic [MAGIC_W-1:0] MAGIC_DIV10  = 18'd52429;
    localparam logic [MAGIC_W-1:0] MAGIC_UNIT   = 18'd1;

    localparam logic [SEG_W-1:0] DEGREE_GLYPH = 7'h63;

    localparam logic [1:0] FRAME_LEAD   = 2'd0;
    localparam logic [1:0] FRAME_MID    = 2'd1;
    localparam logic [1:0] FRAME_TAIL   = 2'd2;
    localparam logic [1:0] FRAME_DEGREE = 2'd3;

    typedef enum logic [1:0] {
        RNG_ONES,
        RNG_TENS,
        RNG_HUNDS
    } range_t;

    typedef struct packed {
        logic [DIGIT_W-1:0] hund;
        logic [DIGIT_W-1:0] tens;
        logic [DIGIT_W-1:0] ones;
        range_t             range;
    } digits_t;

    function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] digit);
        logic [SEG_W-1:0] seg;
        case (digit)
            4'd0: seg = 7'h3F;
            4'd1: seg = 7'h06;
            4'd2: seg = 7'h5B;
            4'd3: seg = 7'h4F;
            4'd4: seg = 7'h66;
            4'd5: seg = 7'h6D;
            4'd6: seg = 7'h7D;
            4'd7: seg = 7'h07;
            4'd8: seg = 7'h7F;
            4'd9: seg = 7'h6F;
            default: seg = 7'h00;
        endcase
        return seg;
    endfunction

endpackage

[src/aass_digit_pipe.sv]
module aass_digit_pipe (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [aass_pkg::ANGLE_W-1:0]        in_angle,
    output logic                                out_valid,
    input  logic                                out_ready,
    output aass_pkg::digits_t                   out_digits
);

    // stage valids
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic ld1, ld2, ld3, ld4, ld5;

    // stage 1: saturate, pick range and reciprocal
    logic [aass_pkg::ANGLE_W-1:0] h1_reg, h1_next;
    logic [aass_pkg::MAGIC_W-1:0] magic1_reg, magic1_next;
    aass_pkg::range_t             rng1_reg, rng1_next;

    // stage 2: reciprocal product
    logic [aass_pkg::PROD_W-1:0]  prod2_reg, prod2_next;
    aass_pkg::range_t             rng2_reg;

    // stage 3: three-digit value
    logic [aass_pkg::VAL_W-1:0]   val3_reg, val3_next;
    aass_pkg::range_t             rng3_reg;

    // stage 4: value / 100 and value / 10
    logic [aass_pkg::VAL_W-1:0]   val4_reg;
    logic [3:0]                   q100_4_reg, q100_4_next;
    logic [6:0]                   q10_4_reg, q10_4_next;
    aass_pkg::range_t             rng4_reg;
    logic [15:0]                  mul41;
    logic [17:0]                  mul205;

    // stage 5: digits
    aass_pkg::digits_t            dig5_reg, dig5_next;
    logic [6:0]                   tens7;
    logic [aass_pkg::VAL_W-1:0]   ones10;

    assign ld5 = !v5_reg || out_ready;
    assign ld4 = !v4_reg || ld5;
    assign ld3 = !v3_reg || ld4;
    assign ld2 = !v2_reg || ld3;
    assign ld1 = !v1_reg || ld2;
    assign in_ready = ld1;

    always_comb begin
        h1_next = (in_angle > aass_pkg::ANGLE_MAX) ? aass_pkg::ANGLE_MAX : in_angle;
        if (h1_next >= aass_pkg::HUNDS_MIN) begin
            rng1_next   = aass_pkg::RNG_HUNDS;
            magic1_next = aass_pkg::MAGIC_DIV100;
        end else if (h1_next >= aass_pkg::TENS_MIN) begin
            rng1_next   = aass_pkg::RNG_TENS;
            magic1_next = aass_pkg::MAGIC_DIV10;
        end else begin
            rng1_next   = aass_pkg::RNG_ONES;
            magic1_next = aass_pkg::MAGIC_UNIT;
        end
    end

    assign prod2_next = {{aass_pkg::MAGIC_W{1'b0}}, h1_reg}
                      * {{aass_pkg::ANGLE_W{1'b0}}, magic1_reg};

    always_comb begin
        case (rng2_reg)
            aass_pkg::RNG_HUNDS: val3_next = prod2_reg[33:24];
            aass_pkg::RNG_TENS:  val3_next = prod2_reg[28:19];
            default:             val3_next = prod2_reg[9:0];
        endcase
    end

    // value < 1000: /100 is *41 >> 12, /10 is *205 >> 11
    assign mul41       = {6'd0, val3_reg} * 16'd41;
    assign mul205      = {8'd0, val3_reg} * 18'd205;
    assign q100_4_next = mul41[15:12];
    assign q10_4_next  = mul205[17:11];

    assign tens7  = q10_4_reg - ({q100_4_reg, 3'b000} + {2'b00, q100_4_reg, 1'b0});
    assign ones10 = val4_reg - ({q10_4_reg, 3'b000} + {2'b00, q10_4_reg, 1'b0});

    always_comb begin
        dig5_next.hund  = q100_4_reg;
        dig5_next.tens  = tens7[3:0];
        dig5_next.ones  = ones10[3:0];
        dig5_next.range = rng4_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (ld1) v1_reg <= in_valid;
            if (ld2) v2_reg <= v1_reg;
            if (ld3) v3_reg <= v2_reg;
            if (ld4) v4_reg <= v3_reg;
            if (ld5) v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld1) begin
            h1_reg     <= h1_next;
            magic1_reg <= magic1_next;
            rng1_reg   <= rng1_next;
        end
        if (ld2) begin
            prod2_reg <= prod2_next;
            rng2_reg  <= rng1_reg;
        end
        if (ld3) begin
            val3_reg <= val3_next;
            rng3_reg <= rng2_reg;
        end
        if (ld4) begin
            val4_reg   <= val3_reg;
            q100_4_reg <= q100_4_next;
            q10_4_reg  <= q10_4_next;
            rng4_reg   <= rng3_reg;
        end
        if (ld5) begin
            dig5_reg <= dig5_next;
        end
    end

    assign out_valid  = v5_reg;
    assign out_digits = dig5_reg;

endmodule

[src/aass_frame_ser.sv]
module aass_frame_ser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  aass_pkg::digits_t   in_digits,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,
    output logic                m_tlast
);

    aass_pkg::digits_t              held_reg, held_next;
    logic                           busy_reg, busy_next;
    logic [1:0]                     frame_reg, frame_next;

    logic                           m_tvalid_reg, m_tvalid_next;
    logic [1:0]                     pos_reg, pos_next;
    logic [aass_pkg::SEG_W-1:0]     seg_reg, seg_next;
    logic                           dp_reg, dp_next;
    logic                           last_reg, last_next;

    logic                           out_ld;
    logic [aass_pkg::SEG_W-1:0]     frame_seg;
    logic                           frame_dp;
    logic                           frame_last;

    assign out_ld   = !m_tvalid_reg || m_tready;
    // take the next angle while its predecessor's degree beat is loaded
    assign in_ready = !busy_reg || (out_ld && frame_reg == aass_pkg::FRAME_DEGREE);

    always_comb begin
        frame_seg  = aass_pkg::DEGREE_GLYPH;
        frame_dp   = 1'b0;
        frame_last = 1'b0;
        case (frame_reg)
            aass_pkg::FRAME_LEAD: begin
                frame_seg = aass_pkg::seg_of(held_reg.hund);
                frame_dp  = (held_reg.range == aass_pkg::RNG_ONES);
            end
            aass_pkg::FRAME_MID: begin
                frame_seg = aass_pkg::seg_of(held_reg.tens);
                frame_dp  = (held_reg.range == aass_pkg::RNG_TENS);
            end
            aass_pkg::FRAME_TAIL: begin
                frame_seg = aass_pkg::seg_of(held_reg.ones);
            end
            default: begin
                frame_last = 1'b1;
            end
        endcase
    end

    always_comb begin
        held_next     = held_reg;
        busy_next     = busy_reg;
        frame_next    = frame_reg;
        m_tvalid_next = m_tvalid_reg;
        pos_next      = pos_reg;
        seg_next      = seg_reg;
        dp_next       = dp_reg;
        last_next     = last_reg;
        if (out_ld) begin
            m_tvalid_next = busy_reg;
            pos_next      = frame_reg;
            seg_next      = frame_seg;
            dp_next       = frame_dp;
            last_next     = frame_last;
            if (busy_reg) begin
                // wraps back to the lead frame after the degree beat
                frame_next = frame_reg + 2'd1;
                if (frame_reg == aass_pkg::FRAME_DEGREE) begin
                    busy_next = 1'b0;
                end
            end
        end
        if (in_valid && in_ready) begin
            held_next = in_digits;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            frame_reg    <= aass_pkg::FRAME_LEAD;
            m_tvalid_reg <= 1'b0;
        end else begin
            busy_reg     <= busy_next;
            frame_reg    <= frame_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        held_reg <= held_next;
        pos_reg  <= pos_next;
        seg_reg  <= seg_next;
        dp_reg   <= dp_next;
        last_reg <= last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, dp_reg, seg_reg, pos_reg};
    assign m_tlast  = last_reg;

endmodule

[src/autorange_angle_seven_segment_core.sv]
// Auto-ranging angle display driver: each input beat is an angle in hundredths
// of a degree (values above 99999 read as 999.99) and yields four output beats
// in scan order: three digit frames carrying position, segment pattern
// (bit0 = A .. bit6 = G) and decimal point, then a degree-symbol frame marked
// with m_tlast. Range and digits are truncated: 100 and up shows hundreds,
// tens, ones; 10 to 99.99 shows tens, ones, tenths with the point on position
// 1; below 10 shows ones, tenths, hundredths with the point on position 0.
// A five-stage pipeline (saturate and range, reciprocal multiply, scale,
// divide by 100 and 10, digit split) feeds a frame serializer whose output
// register drives the result port. An angle's first beat passes the pipeline
// stages, the serializer's held register and its output register. A new angle
// is taken as the prior degree beat loads; its four beats bound throughput.
`include "assert_macros.svh"

module autorange_angle_seven_segment_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [16:0] angle_hundredths
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [1:0] digit_position, [8:2] segment_pattern,
                                   // [9] decimal_point
    output logic        m_tlast    // last_frame
);

    logic              dig_valid;
    logic              dig_ready;
    aass_pkg::digits_t dig;

    aass_digit_pipe u_digit_pipe (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_angle   (s_tdata[aass_pkg::ANGLE_W-1:0]),
        .out_valid  (dig_valid),
        .out_ready  (dig_ready),
        .out_digits (dig)
    );

    aass_frame_ser u_frame_ser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (dig_valid),
        .in_ready  (dig_ready),
        .in_digits (dig),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    `ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_tvalid)
    `ASSERT_PROP(a_frames_unbroken, aclk, aresetn, (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
    `ASSERT_PROP(a_frame_order, aclk, aresetn, (m_tvalid && m_tready && !m_tlast) |=> (m_tdata[1:0] == $past(m_tdata[1:0]) + 2'd1))
    `ASSERT_PROP(a_last_on_degree, aclk, aresetn, m_tvalid |-> (m_tlast == (m_tdata[1:0] == aass_pkg::FRAME_DEGREE)))
    `ASSERT_PROP(a_no_late_point, aclk, aresetn, (m_tvalid && m_tdata[1]) |-> !m_tdata[9])

endmodule
